@@ sv/hsm_pkg.sv @@
// Shared types and constants for the hat switch to stick merge unit.
`default_nettype none

package hsm_pkg;

  // One input transfer: raw hat word and the current stick axes.
  typedef struct packed {
    logic        [31:0] hat_word;
    logic signed [31:0] stick_x;
    logic signed [31:0] stick_y;
  } in_item_t;

  // One result transfer: axes after the hat has been merged in.
  typedef struct packed {
    logic signed [31:0] merged_x;
    logic signed [31:0] merged_y;
  } out_item_t;

  // Merge mode codes as held in the merge_mode register.
  typedef enum logic [1:0] {
    MODE_HAT_ONLY    = 2'd0,
    MODE_HAT_PRIO    = 2'd1,
    MODE_STICK_PRIO  = 2'd2,
    MODE_PASS        = 2'd3
  } merge_mode_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_MERGE_MODE = 3'd0,
    REG_OVERRIDE_X = 3'd1,
    REG_OVERRIDE_Y = 3'd2,
    REG_DEADZONE   = 3'd3,
    REG_X_MIN      = 3'd4,
    REG_X_MAX      = 3'd5,
    REG_Y_MIN      = 3'd6,
    REG_Y_MAX      = 3'd7
  } reg_index_e;

  localparam int unsigned PADDR_W = 5;

  // Configuration as seen by the datapath.
  typedef struct packed {
    merge_mode_e        mode;
    logic               override_x;
    logic               override_y;
    logic        [30:0] deadzone;
    logic        [31:0] x_min;
    logic        [31:0] x_max;
    logic        [31:0] y_min;
    logic        [31:0] y_max;
  } cfg_t;

  // Reset values of the configuration registers.
  localparam logic [31:0] X_MIN_RST = 32'hFFFF_8001;
  localparam logic [31:0] X_MAX_RST = 32'h0000_7FFF;
  localparam logic [31:0] Y_MIN_RST = 32'hFFFF_8001;
  localparam logic [31:0] Y_MAX_RST = 32'h0000_7FFF;

  // Hat word low half that marks a centered hat.
  localparam logic [15:0] HAT_CENTERED = 16'hFFFF;

  // floor(x / 100) = (x * RECIP_100) >> 37 for every 32-bit x.
  localparam logic [30:0] RECIP_100 = 31'd1374389535;
  // floor(2^35 / 360); the quotient it gives is low by at most one.
  localparam logic [26:0] RECIP_360 = 27'd95443717;

  // Angle decode bounds in degrees, all inclusive.
  localparam logic [8:0] DEG_45  = 9'd45;
  localparam logic [8:0] DEG_135 = 9'd135;
  localparam logic [8:0] DEG_225 = 9'd225;
  localparam logic [8:0] DEG_315 = 9'd315;
  localparam logic [9:0] DEG_360 = 10'd360;

endpackage

`default_nettype wire

@@ sv/hsm_regs.sv @@
// APB-style configuration register file of the hat merge unit.
`default_nettype none

module hsm_regs
  import hsm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t       cfg_q;
  reg_index_e idx;
  logic       wr_en;

  assign idx    = reg_index_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= MODE_HAT_PRIO;
      cfg_q.override_x <= 1'b1;
      cfg_q.override_y <= 1'b1;
      cfg_q.deadzone   <= '0;
      cfg_q.x_min      <= X_MIN_RST;
      cfg_q.x_max      <= X_MAX_RST;
      cfg_q.y_min      <= Y_MIN_RST;
      cfg_q.y_max      <= Y_MAX_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MERGE_MODE: cfg_q.mode       <= merge_mode_e'(pwdata[1:0]);
        REG_OVERRIDE_X: cfg_q.override_x <= pwdata[0];
        REG_OVERRIDE_Y: cfg_q.override_y <= pwdata[0];
        REG_DEADZONE:   cfg_q.deadzone   <= pwdata[30:0];
        REG_X_MIN:      cfg_q.x_min      <= pwdata;
        REG_X_MAX:      cfg_q.x_max      <= pwdata;
        REG_Y_MIN:      cfg_q.y_min      <= pwdata;
        REG_Y_MAX:      cfg_q.y_max      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MERGE_MODE: prdata = {30'd0, cfg_q.mode};
      REG_OVERRIDE_X: prdata = {31'd0, cfg_q.override_x};
      REG_OVERRIDE_Y: prdata = {31'd0, cfg_q.override_y};
      REG_DEADZONE:   prdata = {1'b0, cfg_q.deadzone};
      REG_X_MIN:      prdata = cfg_q.x_min;
      REG_X_MAX:      prdata = cfg_q.x_max;
      REG_Y_MIN:      prdata = cfg_q.y_min;
      REG_Y_MAX:      prdata = cfg_q.y_max;
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/hsm_angle.sv @@
// Three-stage reduction of a hat word to whole degrees modulo 360.
`default_nettype none

module hsm_angle
  import hsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [2:0]  ld_i,
  input  wire logic [31:0] hat_i,
  output logic      [8:0]  deg_o
);

  logic [62:0] prod_100;
  logic [25:0] quot_d, quot_q, quot2_q;
  logic [52:0] prod_360;
  logic [16:0] turns_d, turns_q;
  logic [25:0] rem_full;
  logic [9:0]  rem;
  logic [8:0]  deg_d, deg_q;

  // Stage 1: hundredths of a degree to whole degrees.
  assign prod_100 = 63'(hat_i) * 63'(RECIP_100);
  assign quot_d   = prod_100[62:37];

  // Stage 2: estimate of the number of full turns.
  assign prod_360 = 53'(quot_q) * 53'(RECIP_360);
  assign turns_d  = prod_360[51:35];

  // Stage 3: remainder with one correction step.
  assign rem_full = quot2_q - 26'(turns_q) * 26'd360;
  assign rem      = rem_full[9:0];
  always_comb begin
    if (rem >= DEG_360) begin
      deg_d = 9'(rem - DEG_360);
    end else begin
      deg_d = rem[8:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      quot_q <= quot_d;
    end
    if (ld_i[1]) begin
      turns_q <= turns_d;
      quot2_q <= quot_q;
    end
    if (ld_i[2]) begin
      deg_q <= deg_d;
    end
  end

  assign deg_o = deg_q;

endmodule

`default_nettype wire

@@ sv/hsm_merge.sv @@
// Direction decode and axis merge for one report.
`default_nettype none

module hsm_merge
  import hsm_pkg::*;
#(
  parameter int unsigned AXIS_WIDTH = 32
) (
  input  wire logic                         hat_on_i,
  input  wire logic [8:0]                   deg_i,
  input  wire logic signed [AXIS_WIDTH-1:0] sx_i,
  input  wire logic signed [AXIS_WIDTH-1:0] sy_i,
  input  wire logic                         centered_i,
  input  wire cfg_t                         cfg_i,
  output out_item_t                         item_o
);

  logic up, down, right, left, active;
  logic signed [AXIS_WIDTH-1:0] xlo, xhi, ylo, yhi, xmid, ymid, hx, hy, rx, ry;

  function automatic logic signed [AXIS_WIDTH-1:0] mid_of(
    input logic signed [AXIS_WIDTH-1:0] lo,
    input logic signed [AXIS_WIDTH-1:0] hi
  );
    logic signed [AXIS_WIDTH:0] sum;
    logic signed [AXIS_WIDTH:0] adj;
    sum = {lo[AXIS_WIDTH-1], lo} + {hi[AXIS_WIDTH-1], hi};
    // Round toward zero: bias negative sums by one before the shift.
    adj = sum + {{AXIS_WIDTH{1'b0}}, sum[AXIS_WIDTH]};
    adj = adj >>> 1;
    return adj[AXIS_WIDTH-1:0];
  endfunction

  assign xlo  = cfg_i.x_min[AXIS_WIDTH-1:0];
  assign xhi  = cfg_i.x_max[AXIS_WIDTH-1:0];
  assign ylo  = cfg_i.y_min[AXIS_WIDTH-1:0];
  assign yhi  = cfg_i.y_max[AXIS_WIDTH-1:0];
  assign xmid = mid_of(xlo, xhi);
  assign ymid = mid_of(ylo, yhi);

  assign up     = hat_on_i & ((deg_i >= DEG_315) | (deg_i <= DEG_45));
  assign down   = hat_on_i & (deg_i >= DEG_135) & (deg_i <= DEG_225);
  assign right  = hat_on_i & (deg_i >= DEG_45) & (deg_i <= DEG_135);
  assign left   = hat_on_i & (deg_i >= DEG_225) & (deg_i <= DEG_315);
  assign active = up | down | right | left;

  assign hx = right ? xhi : (left ? xlo : xmid);
  assign hy = down ? yhi : (up ? ylo : ymid);

  always_comb begin
    rx = sx_i;
    ry = sy_i;
    case (cfg_i.mode) inside
      MODE_HAT_ONLY: begin
        if (cfg_i.override_x) rx = hx;
        if (cfg_i.override_y) ry = hy;
      end
      MODE_HAT_PRIO, MODE_STICK_PRIO: begin
        if (active && (cfg_i.mode == MODE_HAT_PRIO || centered_i)) begin
          if ((right || left) && cfg_i.override_x) rx = hx;
          if ((up || down) && cfg_i.override_y) ry = hy;
        end
      end
      default: ;
    endcase
  end

  assign item_o.merged_x = 32'(rx);
  assign item_o.merged_y = 32'(ry);

endmodule

`default_nettype wire

@@ sv/hat_switch_to_stick_merge_unit.sv @@
// Top level of the hat switch to stick merge unit.
`default_nettype none

// The unit takes one report per transfer (a raw hat word and the stick X and
// Y values) and returns one result per report with the hat direction merged
// into the axes. Reports may be accepted in every cycle while the downstream
// side takes results; each passes from the input register through the
// stages to the result register. Those stages come from the reduction of
// the hat word to whole degrees: one multiply by a reciprocal of 100, one
// by a reciprocal of 360, and a final correction step, each in its own
// stage, followed by the direction decode and merge. The stages carry their
// own valid bits and collapse bubbles, so the input keeps taking reports
// while a result waits for the downstream side, until every stage is full.
// Axis values are AXIS_WIDTH-bit two's complement numbers held in the low
// bits of the stick fields and range registers; results come back
// sign-extended to 32 bits. The eight configuration registers sit on the APB
// port at byte addresses 0 to 28 and must only be written while the unit is idle.
module hat_switch_to_stick_merge_unit
  import hsm_pkg::*;
#(
  parameter int unsigned AXIS_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int unsigned NSTAGE = 5;

  cfg_t cfg;

  // Valid bit and load enable of every stage. Stage 0 is the input register,
  // stage 4 the result register.
  logic [NSTAGE-1:0] valid_d, valid_q;
  logic [NSTAGE:0]   rdy;
  logic [NSTAGE-1:0] ld;

  // Input register.
  logic [31:0]                  hat_q;
  logic signed [AXIS_WIDTH-1:0] sx_q, sy_q;

  // Stick values, centered flag and hat presence riding along with the angle.
  logic signed [AXIS_WIDTH-1:0] sx_pipe_q [1:3];
  logic signed [AXIS_WIDTH-1:0] sy_pipe_q [1:3];
  logic                         cen_pipe_q [1:3];
  logic                         hat_on_pipe_q [1:3];

  logic [AXIS_WIDTH-1:0] mag_x, mag_y;
  logic                  centered_d, hat_on_d;
  logic [8:0]            deg;
  out_item_t             result_d, result_q;

  hsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A stage can take new data when it is empty or when its content moves on.
  always_comb begin
    rdy[NSTAGE] = out_ready_i;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
  end

  assign ld         = rdy[NSTAGE-1:0];
  assign in_ready_o = rdy[0];

  always_comb begin
    valid_d[0] = ld[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      if (ld[k]) begin
        valid_d[k] = valid_q[k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Magnitudes are exact in AXIS_WIDTH unsigned bits, the most negative value
  // included.
  assign mag_x      = sx_q[AXIS_WIDTH-1] ? AXIS_WIDTH'(-sx_q) : AXIS_WIDTH'(sx_q);
  assign mag_y      = sy_q[AXIS_WIDTH-1] ? AXIS_WIDTH'(-sy_q) : AXIS_WIDTH'(sy_q);
  assign centered_d = (32'(mag_x) <= {1'b0, cfg.deadzone}) &&
                      (32'(mag_y) <= {1'b0, cfg.deadzone});
  assign hat_on_d   = (hat_q[15:0] != HAT_CENTERED);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      hat_q <= in_item_i.hat_word;
      sx_q  <= in_item_i.stick_x[AXIS_WIDTH-1:0];
      sy_q  <= in_item_i.stick_y[AXIS_WIDTH-1:0];
    end
    if (ld[1]) begin
      sx_pipe_q[1]     <= sx_q;
      sy_pipe_q[1]     <= sy_q;
      cen_pipe_q[1]    <= centered_d;
      hat_on_pipe_q[1] <= hat_on_d;
    end
    for (int k = 2; k <= 3; k++) begin
      if (ld[k]) begin
        sx_pipe_q[k]     <= sx_pipe_q[k-1];
        sy_pipe_q[k]     <= sy_pipe_q[k-1];
        cen_pipe_q[k]    <= cen_pipe_q[k-1];
        hat_on_pipe_q[k] <= hat_on_pipe_q[k-1];
      end
    end
    if (ld[4]) begin
      result_q <= result_d;
    end
  end

  hsm_angle u_angle (
    .clk_i (clk_i),
    .ld_i  (ld[3:1]),
    .hat_i (hat_q),
    .deg_o (deg)
  );

  hsm_merge #(
    .AXIS_WIDTH (AXIS_WIDTH)
  ) u_merge (
    .hat_on_i   (hat_on_pipe_q[3]),
    .deg_i      (deg),
    .sx_i       (sx_pipe_q[3]),
    .sy_i       (sy_pipe_q[3]),
    .centered_i (cen_pipe_q[3]),
    .cfg_i      (cfg),
    .item_o     (result_d)
  );

  assign out_valid_o = valid_q[NSTAGE-1];
  assign out_item_o  = result_q;

endmodule

`default_nettype wire

@@ tb/hsm_merge_checker.sv @@
// Checker that predicts and compares every result of the hat switch to stick merge unit.
`timescale 1ns / 1ps

module hsm_merge_checker
  import hsm_pkg::*;
#(
  parameter int unsigned AXIS_W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_item_t          out_item_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  cfg_t        shadow_cfg;
  out_item_t   expected_merges[$];
  out_item_t   oldest;
  int unsigned fails = 0;

  assign fail_count_o = fails;

  // Takes the low AXIS_W bits of a value as a two's complement number.
  function automatic longint axis_value(logic [31:0] v);
    longint m;
    m = longint'(v) & ((longint'(1) << AXIS_W) - 1);
    if (m[AXIS_W-1]) m = m - (longint'(1) << AXIS_W);
    return m;
  endfunction

  function automatic out_item_t predict_merge(in_item_t it, cfg_t c);
    longint      sx, sy, xlo, xhi, ylo, yhi, hx, hy, rx, ry, ax, ay;
    int          dx, dy;
    int unsigned deg;
    bit          active, centered;
    out_item_t   res;
    sx  = axis_value(it.stick_x);
    sy  = axis_value(it.stick_y);
    xlo = axis_value(c.x_min);
    xhi = axis_value(c.x_max);
    ylo = axis_value(c.y_min);
    yhi = axis_value(c.y_max);
    rx  = sx;
    ry  = sy;
    dx  = 0;
    dy  = 0;
    if (it.hat_word[15:0] != HAT_CENTERED) begin
      deg = (it.hat_word / 32'd100) % DEG_360;
      if (deg >= DEG_315 || deg <= DEG_45) dy = -1;
      if (deg >= DEG_135 && deg <= DEG_225) dy = 1;
      if (deg >= DEG_45 && deg <= DEG_135) dx = 1;
      if (deg >= DEG_225 && deg <= DEG_315) dx = -1;
    end
    active = (dx != 0) || (dy != 0);
    // The midpoint sum is formed in 64 bits and truncated toward zero.
    hx = (dx > 0) ? xhi : ((dx < 0) ? xlo : (xlo + xhi) / 2);
    hy = (dy > 0) ? yhi : ((dy < 0) ? ylo : (ylo + yhi) / 2);
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    centered = (ax <= longint'(c.deadzone)) && (ay <= longint'(c.deadzone));
    case (c.mode) inside
      MODE_HAT_ONLY: begin
        if (c.override_x) rx = hx;
        if (c.override_y) ry = hy;
      end
      MODE_HAT_PRIO, MODE_STICK_PRIO: begin
        if (active && (c.mode == MODE_HAT_PRIO || centered)) begin
          if (dx != 0 && c.override_x) rx = hx;
          if (dy != 0 && c.override_y) ry = hy;
        end
      end
      default: ;
    endcase
    res.merged_x = rx[31:0];
    res.merged_y = ry[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: MISMATCH: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg.mode       <= MODE_HAT_PRIO;
      shadow_cfg.override_x <= 1'b1;
      shadow_cfg.override_y <= 1'b1;
      shadow_cfg.deadzone   <= '0;
      shadow_cfg.x_min      <= X_MIN_RST;
      shadow_cfg.x_max      <= X_MAX_RST;
      shadow_cfg.y_min      <= Y_MIN_RST;
      shadow_cfg.y_max      <= Y_MAX_RST;
      expected_merges.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_merges.size() == 0) begin
          report_mismatch($sformatf("result x=%h y=%h with nothing pending",
                                    out_item_i.merged_x, out_item_i.merged_y));
        end else begin
          oldest = expected_merges.pop_front();
          if (out_item_i.merged_x !== oldest.merged_x)
            report_mismatch($sformatf("merged_x expected %h got %h",
                                      oldest.merged_x, out_item_i.merged_x));
          if (out_item_i.merged_y !== oldest.merged_y)
            report_mismatch($sformatf("merged_y expected %h got %h",
                                      oldest.merged_y, out_item_i.merged_y));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_merges = {expected_merges, predict_merge(in_item_i, shadow_cfg)};
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_index_e'(paddr_i[PADDR_W-1:2]))
          REG_MERGE_MODE: shadow_cfg.mode       <= merge_mode_e'(pwdata_i[1:0]);
          REG_OVERRIDE_X: shadow_cfg.override_x <= pwdata_i[0];
          REG_OVERRIDE_Y: shadow_cfg.override_y <= pwdata_i[0];
          REG_DEADZONE:   shadow_cfg.deadzone   <= pwdata_i[30:0];
          REG_X_MIN:      shadow_cfg.x_min      <= pwdata_i;
          REG_X_MAX:      shadow_cfg.x_max      <= pwdata_i;
          REG_Y_MIN:      shadow_cfg.y_min      <= pwdata_i;
          REG_Y_MAX:      shadow_cfg.y_max      <= pwdata_i;
          default: ;
        endcase
      end
      pending_o <= expected_merges.size();
    end
  end

endmodule

@@ tb/hat_switch_to_stick_merge_unit_tb.sv @@
// Top of the testbench: clock, reset, stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module hat_switch_to_stick_merge_unit_tb;
  import hsm_pkg::*;

  // The limit only catches a hung handshake.
  localparam int unsigned CYCLE_LIMIT    = 200000;
  // The unit is five stages deep; the margin of quiet covers any straggler.
  localparam int unsigned LATENCY_MARGIN = 10;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned RANDOM_PHASES  = 9;
  localparam int unsigned PHASE_ITEMS    = 48;
  // Degrees on either side of each decode bound.
  localparam int unsigned BOUND_DEG [14] =
    '{0, 44, 45, 46, 134, 135, 136, 224, 225, 226, 314, 315, 316, 359};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;

  // Sender pacing: items go out in bursts, and between bursts the valid
  // may drop for a random gap. With steady_sender set there are
  // no gaps at all.
  int unsigned burst_left    = 0;
  bit          steady_sender = 1'b0;
  // Each increment asks the receiver for one long hold-off.
  int unsigned hold_requests = 0;

  hat_switch_to_stick_merge_unit #(
    .AXIS_WIDTH(32)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  hsm_merge_checker #(
    .AXIS_W(32)
  ) u_merge_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t make_report(logic [31:0] hat, logic [31:0] sx,
                                           logic [31:0] sy);
    in_item_t it;
    it.hat_word = hat;
    it.stick_x  = sx;
    it.stick_y  = sy;
    return it;
  endfunction

  function automatic cfg_t make_cfg(merge_mode_e mode, logic ovx, logic ovy,
                                    logic [30:0] dz, logic [31:0] xlo,
                                    logic [31:0] xhi, logic [31:0] ylo,
                                    logic [31:0] yhi);
    cfg_t c;
    c.mode       = mode;
    c.override_x = ovx;
    c.override_y = ovy;
    c.deadzone   = dz;
    c.x_min      = xlo;
    c.x_max      = xhi;
    c.y_min      = ylo;
    c.y_max      = yhi;
    return c;
  endfunction

  // A hat word: centered with random upper half, fully random, near a
  // decode bound (possibly past a full turn), or a plain in-range angle.
  function automatic logic [31:0] pick_hat();
    logic [31:0] deg;
    case ($urandom_range(0, 7))
      0: return {16'($urandom), HAT_CENTERED};
      1: return $urandom;
      2, 3: begin
        deg = BOUND_DEG[$urandom_range(0, 13)];
        return deg * 100 + $urandom_range(0, 99) + 36000 * $urandom_range(0, 3);
      end
      default: return $urandom_range(0, 35999);
    endcase
  endfunction

  // A stick value that lands around the deadzone edge often enough to
  // exercise both sides of the centered test.
  function automatic logic [31:0] pick_axis(logic [30:0] dz);
    logic [31:0] mag;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: mag = {1'b0, dz};
      5: mag = {1'b0, dz} + 32'd1;
      6: mag = (dz == 0) ? 32'd0 : $urandom_range(0, dz);
      default: mag = $urandom_range(0, 100);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // One axis range: unset style, full span, degenerate, random, both at the
  // top (the midpoint sum overflows 32 bits) or reversed.
  function automatic void pick_range(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] v;
    v = $urandom_range(0, 1) ? $urandom_range(1, 32767) : $urandom;
    case ($urandom_range(0, 5))
      0: begin lo = -v; hi = v; end
      1: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
      2: begin lo = v; hi = v; end
      3: begin lo = $urandom; hi = $urandom; end
      4: begin lo = 32'h7FFF_FFFF; hi = 32'h7FFF_FFFF; end
      default: begin lo = v; hi = -v; end
    endcase
  endfunction

  function automatic cfg_t pick_cfg(merge_mode_e mode);
    cfg_t c;
    c.mode       = mode;
    c.override_x = 1'($urandom_range(0, 1));
    c.override_y = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: c.deadzone = '0;
      1: c.deadzone = '1;
      2: c.deadzone = 31'($urandom_range(0, 1000));
      default: c.deadzone = 31'($urandom);
    endcase
    pick_range(c.x_min, c.x_max);
    pick_range(c.y_min, c.y_max);
    return c;
  endfunction

  // Offers one item and returns at the edge where it is transferred. The
  // next call either keeps valid high with new data or drops it for a gap,
  // so valid gets only one assignment in that time step.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until the checker has nothing outstanding.
  // The first edge lets the count of the last transfer settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes all eight registers back to back. Each write is a setup phase
  // followed by an access phase; the next setup follows the access directly,
  // so psel stays high across the whole sequence.
  task automatic write_config(cfg_t c);
    logic [31:0] vals [8];
    vals[REG_MERGE_MODE] = 32'(c.mode);
    vals[REG_OVERRIDE_X] = 32'(c.override_x);
    vals[REG_OVERRIDE_Y] = 32'(c.override_y);
    vals[REG_DEADZONE]   = 32'(c.deadzone);
    vals[REG_X_MIN]      = c.x_min;
    vals[REG_X_MAX]      = c.x_max;
    vals[REG_Y_MIN]      = c.y_min;
    vals[REG_Y_MAX]      = c.y_max;
    for (int i = 0; i < 8; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index_e'(i), 2'b00};
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: segments of random length, each with its own stall pattern
  // (always ready, half, a quarter, mostly ready). When a long hold-off is
  // asked for, ready stays low through it so the pipeline fills up and
  // the input side has to stall.
  initial begin : receiver
    int unsigned style;
    int unsigned seg_len;
    int unsigned holds_served;
    holds_served = 0;
    out_ready    = 1'b0;
    forever begin
      style   = $urandom_range(0, 3);
      seg_len = $urandom_range(8, 60);
      repeat (seg_len) begin
        @(posedge clk);
        if (hold_requests != holds_served) begin
          holds_served = hold_requests;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    cfg_t     c;
    in_item_t directed[$];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset configuration (hat priority, +/-32767).
    // Centered words, including two with a nonzero upper half, then every
    // decode region and each diagonal, the wrap at 360 degrees and the
    // largest non-centered hat word. The stick takes its extremes along the way.
    directed = {directed, make_report(32'h0000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000)};
    directed = {directed, make_report(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF)};
    directed = {directed, make_report(32'h0001_FFFF, 32'h0000_0011, 32'hFFFF_FFEE)};
    directed = {directed, make_report(32'd0,     32'h8000_0000, 32'h7FFF_FFFF)};
    directed = {directed, make_report(32'd4499,  32'd5,         32'd6)};
    directed = {directed, make_report(32'd4500,  32'd5,         32'd6)};
    directed = {directed, make_report(32'd9000,  32'hFFFF_FFFF, 32'd0)};
    directed = {directed, make_report(32'd13500, 32'd100,       32'd200)};
    directed = {directed, make_report(32'd18000, 32'd100,       32'd200)};
    directed = {directed, make_report(32'd22500, 32'd100,       32'd200)};
    directed = {directed, make_report(32'd27000, 32'h8000_0000, 32'h8000_0000)};
    directed = {directed, make_report(32'd31500, 32'h7FFF_FFFF, 32'h7FFF_FFFF)};
    directed = {directed, make_report(32'd35999, 32'd1,         32'd1)};
    directed = {directed, make_report(32'd36000, 32'd1,         32'd1)};
    directed = {directed, make_report(32'hFFFF_FFFE, 32'd3,     32'd4)};
    foreach (directed[i]) send_item(directed[i]);

    // Stick priority with the widest deadzone: the most negative stick value
    // still lies outside it. Full X span and a Y range whose midpoint sum
    // overflows 32 bits.
    wait_idle();
    write_config(make_cfg(MODE_STICK_PRIO, 1'b1, 1'b1, '1, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(make_report(32'd0,     32'h8000_0000, 32'd0));
    send_item(make_report(32'd9000,  32'h7FFF_FFFF, 32'h8000_0001));
    send_item(make_report(32'd22500, 32'd0,         32'd0));
    send_item(make_report(32'h1234_FFFF, 32'd7,     32'd8));

    // Hat only with the Y override off: a centered hat still drives X to
    // its midpoint, and Y passes through.
    wait_idle();
    write_config(make_cfg(MODE_HAT_ONLY, 1'b1, 1'b0, '0, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'hFFFF_FFFD, 32'h0000_0000));
    send_item(make_report(32'h0000_FFFF, 32'd9,     32'd10));
    send_item(make_report(32'd13500,     32'd9,     32'd10));

    // The unused mode code: both stick values pass through.
    wait_idle();
    write_config(make_cfg(MODE_PASS, 1'b1, 1'b1, 31'd5, 32'd1, 32'd2,
                          32'd3, 32'd4));
    send_item(make_report(32'd0,     32'd1, 32'd2));
    send_item(make_report(32'd27000, 32'h8000_0000, 32'h7FFF_FFFF));

    // Random phases, each with its own configuration. The first two use the
    // extreme settings; mode cycles through all four codes otherwise. One
    // phase runs under a long receiver hold-off with a steady sender, and
    // another runs without sender gaps. Every phase starts once the unit has
    // drained, which is also the sender's pause for all results.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p == 0)
        c = make_cfg(MODE_STICK_PRIO, 1'b1, 1'b1, '1, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      else if (p == 1)
        c = make_cfg(MODE_HAT_ONLY, 1'b0, 1'b0, '0, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      else
        c = pick_cfg(merge_mode_e'(p % 4));
      write_config(c);
      steady_sender = (p == 3) || (p == 6);
      if (p == 3) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(make_report(pick_hat(), pick_axis(c.deadzone), pick_axis(c.deadzone)));
    end

    // Wind down: wait for every result, then give the pipeline time to
    // show any extra transfer before the verdict.
    wait_idle();
    repeat (LATENCY_MARGIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
